FILE: design/llavg_pkg.sv
// Shared types, codes and constants for the light level averager.
// Used by the interfaces, the register block, the divider and the top level.
// Depends on nothing.
`timescale 1ns / 1ps

package llavg_pkg;

    localparam int DEPTH_DEF = 8;

    localparam int LUX_W    = 18;
    localparam int RAW_W    = 19;
    localparam int TIME_W   = 32;
    localparam int CNT_W    = 32;
    localparam int LEVEL_W  = 3;
    localparam int STATUS_W = 2;
    localparam int MODE_W   = 2;
    localparam int APB_AW   = 5;
    localparam int APB_DW   = 32;
    localparam int IDX_W    = APB_AW - 2;

    // Event codes carried in the mode field.
    localparam logic [MODE_W-1:0] MODE_SAMPLE = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ERROR  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CHECK  = 2'd2;

    // Status codes.
    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_STALE = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_ERROR = 2'd2;

    // Light levels.
    localparam logic [LEVEL_W-1:0] LEVEL_DARK        = 3'd0;
    localparam logic [LEVEL_W-1:0] LEVEL_DIM         = 3'd1;
    localparam logic [LEVEL_W-1:0] LEVEL_NORMAL      = 3'd2;
    localparam logic [LEVEL_W-1:0] LEVEL_BRIGHT      = 3'd3;
    localparam logic [LEVEL_W-1:0] LEVEL_VERY_BRIGHT = 3'd4;

    // Register indexes (byte address divided by four).
    localparam logic [IDX_W-1:0] REG_TIMEOUT = 3'd0;
    localparam logic [IDX_W-1:0] REG_DARK    = 3'd1;
    localparam logic [IDX_W-1:0] REG_DIM     = 3'd2;
    localparam logic [IDX_W-1:0] REG_NORMAL  = 3'd3;
    localparam logic [IDX_W-1:0] REG_BRIGHT  = 3'd4;

    // Register reset values; the limits are 10, 100, 500 and 1000 lux in quarter lux.
    localparam logic [TIME_W-1:0] TIMEOUT_RST = 32'd1000;
    localparam logic [LUX_W-1:0]  DARK_RST    = 18'd40;
    localparam logic [LUX_W-1:0]  DIM_RST     = 18'd400;
    localparam logic [LUX_W-1:0]  NORMAL_RST  = 18'd2000;
    localparam logic [LUX_W-1:0]  BRIGHT_RST  = 18'd4000;

    typedef struct packed {
        logic [TIME_W-1:0] timeout;
        logic [LUX_W-1:0]  dark;
        logic [LUX_W-1:0]  dim;
        logic [LUX_W-1:0]  normal;
        logic [LUX_W-1:0]  bright;
    } cfg_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    // The first limit that the average lies below decides the level.
    function automatic logic [LEVEL_W-1:0] classify(input logic [LUX_W-1:0] avg,
                                                    input cfg_t cfg);
        logic [LEVEL_W-1:0] lvl;
        if (avg < cfg.dark)
        begin
            lvl = LEVEL_DARK;
        end
        else if (avg < cfg.dim)
        begin
            lvl = LEVEL_DIM;
        end
        else if (avg < cfg.normal)
        begin
            lvl = LEVEL_NORMAL;
        end
        else if (avg < cfg.bright)
        begin
            lvl = LEVEL_BRIGHT;
        end
        else
        begin
            lvl = LEVEL_VERY_BRIGHT;
        end
        return lvl;
    endfunction

endpackage

FILE: design/llavg_if.sv
// Valid/ready channel interfaces for the event input and the result output.
// Depends on llavg_pkg for field widths.
`timescale 1ns / 1ps

interface llavg_in_if;
    logic                              valid;
    logic                              ready;
    logic [llavg_pkg::MODE_W-1:0]      mode;
    logic signed [llavg_pkg::RAW_W-1:0] lux;
    logic [llavg_pkg::TIME_W-1:0]      now_ms;

    modport source (output valid, output mode, output lux, output now_ms, input ready);
    modport sink   (input valid, input mode, input lux, input now_ms, output ready);
endinterface

interface llavg_out_if;
    logic                           valid;
    logic                           ready;
    logic                           accepted;
    logic [llavg_pkg::LUX_W-1:0]    last_lux;
    logic [llavg_pkg::LUX_W-1:0]    mean_lux;
    logic [llavg_pkg::LEVEL_W-1:0]  level;
    logic [llavg_pkg::STATUS_W-1:0] status;
    logic [llavg_pkg::CNT_W-1:0]    good_reads;
    logic [llavg_pkg::CNT_W-1:0]    bad_reads;
    logic                           have_sample;

    modport source (output valid, output accepted, output last_lux, output mean_lux,
                    output level, output status, output good_reads, output bad_reads,
                    output have_sample, input ready);
    modport sink   (input valid, input accepted, input last_lux, input mean_lux,
                    input level, input status, input good_reads, input bad_reads,
                    input have_sample, output ready);
endinterface

FILE: design/light_level_averager.sv
// Top level of the light level averager: event sequencer, sample window and result register.
// Depends on llavg_pkg, llavg_if, llavg_regs and llavg_div.
//
//   channel | dir | handshake        | beat
//   --------+-----+------------------+---------------------------------------------
//   req     | in  | valid / ready    | mode, lux, now_ms (one event)
//   rsp     | out | valid / ready    | accepted, last_lux, mean_lux, level,
//           |     |                  | status, good_reads, bad_reads, have_sample
//   apb     | in  | psel / penable   | five configuration registers at 4*i
//
// A valid sample passes from its input beat through the read, divide and classify
// states to the result register; the restoring divider yields one quotient bit per
// cycle. Error events, status checks, rejected samples and the unused code go from
// idle straight to the result state. One event is in flight at a time; req.ready is
// high only while the sequencer is idle, and the result register lets the next event
// in while an earlier result still waits on rsp.ready. Reset is asynchronous and
// active low; the window memory needs no clearing pass, since only entries already
// written ever enter the sum.
`timescale 1ns / 1ps

module light_level_averager #(
    parameter int DEPTH = llavg_pkg::DEPTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [llavg_pkg::APB_AW-1:0]  paddr,
    input  logic [llavg_pkg::APB_DW-1:0]  pwdata,
    output logic [llavg_pkg::APB_DW-1:0]  prdata,
    output logic                          pready,
    llavg_in_if.sink                      req,
    llavg_out_if.source                   rsp
);

    localparam int LUX_W  = llavg_pkg::LUX_W;
    localparam int SLOT_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int FILL_W = $clog2(DEPTH + 1);
    // The window sum can never exceed DEPTH full-scale samples.
    localparam int SUM_W  = LUX_W + $clog2(DEPTH);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_DIV,
        ST_CLASS,
        ST_RESULT
    } state_t;

    state_t                          state_reg;

    // Architectural state.
    logic [SLOT_W-1:0]               slot_reg;
    logic [FILL_W-1:0]               filled_reg;
    logic [SUM_W-1:0]                sum_reg;
    logic [LUX_W-1:0]                last_sample_reg;
    logic [LUX_W-1:0]                mean_reg;
    logic [llavg_pkg::LEVEL_W-1:0]   class_reg;
    logic [llavg_pkg::STATUS_W-1:0]  health_reg;
    logic [llavg_pkg::TIME_W-1:0]    last_time_reg;
    logic [llavg_pkg::CNT_W-1:0]     ok_reg;
    logic [llavg_pkg::CNT_W-1:0]     fail_reg;
    logic                            seen_reg;

    // The event in flight.
    logic [LUX_W-1:0]                sample_reg;
    logic [llavg_pkg::TIME_W-1:0]    now_reg;
    logic                            accepted_reg;

    // Window memory and its registered read port.
    logic [LUX_W-1:0]                window_mem [DEPTH];
    logic [LUX_W-1:0]                old_reg;

    // Result register.
    logic                            out_valid_reg;
    logic                            res_accepted_reg;
    logic [LUX_W-1:0]                res_latest_reg;
    logic [LUX_W-1:0]                res_average_reg;
    logic [llavg_pkg::LEVEL_W-1:0]   res_level_reg;
    logic [llavg_pkg::STATUS_W-1:0]  res_status_reg;
    logic [llavg_pkg::CNT_W-1:0]     res_good_reg;
    logic [llavg_pkg::CNT_W-1:0]     res_bad_reg;
    logic                            res_have_reg;

    logic                            in_acc;
    logic                            good_sample;
    logic                            res_load;
    logic                            full;
    logic [SUM_W-1:0]                sum_next;
    logic [FILL_W-1:0]               filled_next;
    logic [SLOT_W-1:0]               slot_next;
    logic [llavg_pkg::TIME_W-1:0]    elapsed;
    logic                            div_start;
    logic [SUM_W-1:0]                quotient;
    llavg_pkg::div_stat_t            div_stat;
    llavg_pkg::cfg_t                 cfg;

    llavg_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    llavg_div #(
        .DVD_W (SUM_W),
        .DVS_W (FILL_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_next),
        .divisor  (filled_next),
        .quotient (quotient),
        .stat     (div_stat)
    );

    assign req.ready = (state_reg == ST_IDLE);
    assign in_acc    = req.valid & req.ready;

    // A sample event with a non-negative value goes into the window.
    assign good_sample = (req.mode == llavg_pkg::MODE_SAMPLE) && !req.lux[llavg_pkg::RAW_W-1];

    // The result register loads once it is empty or being drained.
    assign res_load = (state_reg == ST_RESULT) && (!out_valid_reg || rsp.ready);

    // Once the ring is full the entry being overwritten leaves the sum.
    assign full        = (filled_reg == FILL_W'(DEPTH));
    assign sum_next    = sum_reg + SUM_W'(sample_reg) - (full ? SUM_W'(old_reg) : '0);
    assign filled_next = full ? filled_reg : filled_reg + 1'b1;
    assign slot_next   = (slot_reg == SLOT_W'(DEPTH - 1)) ? '0 : slot_reg + 1'b1;
    assign div_start   = (state_reg == ST_READ);

    // Wrapping time since the last accepted sample.
    assign elapsed = req.now_ms - last_time_reg;

    assign rsp.valid       = out_valid_reg;
    assign rsp.accepted    = res_accepted_reg;
    assign rsp.last_lux    = res_latest_reg;
    assign rsp.mean_lux    = res_average_reg;
    assign rsp.level       = res_level_reg;
    assign rsp.status      = res_status_reg;
    assign rsp.good_reads  = res_good_reg;
    assign rsp.bad_reads   = res_bad_reg;
    assign rsp.have_sample = res_have_reg;

    // The old entry is read when the event is taken and overwritten in the following cycle, in ST_READ.
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            old_reg <= window_mem[slot_reg];
        end
        if (state_reg == ST_READ)
        begin
            window_mem[slot_reg] <= sample_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            slot_reg         <= '0;
            filled_reg       <= '0;
            sum_reg          <= '0;
            last_sample_reg  <= '0;
            mean_reg         <= '0;
            class_reg        <= llavg_pkg::LEVEL_DARK;
            health_reg       <= llavg_pkg::STATUS_STALE;
            last_time_reg    <= '0;
            ok_reg           <= '0;
            fail_reg         <= '0;
            seen_reg         <= 1'b0;
            sample_reg       <= '0;
            now_reg          <= '0;
            accepted_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            res_accepted_reg <= 1'b0;
            res_latest_reg   <= '0;
            res_average_reg  <= '0;
            res_level_reg    <= llavg_pkg::LEVEL_DARK;
            res_status_reg   <= llavg_pkg::STATUS_OK;
            res_good_reg     <= '0;
            res_bad_reg      <= '0;
            res_have_reg     <= 1'b0;
        end
        else
        begin
            if (res_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (in_acc)
                    begin
                        accepted_reg <= good_sample;
                        state_reg    <= good_sample ? ST_READ : ST_RESULT;
                        case (req.mode)
                            llavg_pkg::MODE_SAMPLE:
                            begin
                                // A negative sample is dropped with no state change.
                                if (good_sample)
                                begin
                                    sample_reg <= req.lux[LUX_W-1:0];
                                    now_reg    <= req.now_ms;
                                end
                            end
                            llavg_pkg::MODE_ERROR:
                            begin
                                fail_reg   <= fail_reg + 1'b1;
                                health_reg <= llavg_pkg::STATUS_ERROR;
                            end
                            llavg_pkg::MODE_CHECK:
                            begin
                                // Within the timeout the status is left alone, so an error stays.
                                if (seen_reg && (elapsed > cfg.timeout))
                                begin
                                    health_reg <= llavg_pkg::STATUS_STALE;
                                end
                            end
                            default: ;
                        endcase
                    end
                end

                ST_READ:
                begin
                    sum_reg         <= sum_next;
                    filled_reg      <= filled_next;
                    slot_reg        <= slot_next;
                    last_sample_reg <= sample_reg;
                    health_reg      <= llavg_pkg::STATUS_OK;
                    last_time_reg   <= now_reg;
                    ok_reg          <= ok_reg + 1'b1;
                    seen_reg        <= 1'b1;
                    state_reg       <= ST_DIV;
                end

                ST_DIV:
                begin
                    if (div_stat.done)
                    begin
                        mean_reg  <= quotient[LUX_W-1:0];
                        state_reg <= ST_CLASS;
                    end
                end

                ST_CLASS:
                begin
                    class_reg <= llavg_pkg::classify(mean_reg, cfg);
                    state_reg <= ST_RESULT;
                end

                ST_RESULT:
                begin
                    if (res_load)
                    begin
                        res_accepted_reg <= accepted_reg;
                        res_latest_reg   <= last_sample_reg;
                        res_average_reg  <= mean_reg;
                        res_level_reg    <= class_reg;
                        res_status_reg   <= health_reg;
                        res_good_reg     <= ok_reg;
                        res_bad_reg      <= fail_reg;
                        res_have_reg     <= seen_reg;
                        state_reg        <= ST_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

`ifndef ASSERT_OFF
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        filled_reg <= FILL_W'(DEPTH))
        else $error("window fill count exceeds the depth");

    a_div_free: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_stat.busy)
        else $error("divider started while still busy");

    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> !req.ready)
        else $error("second event taken while one is in flight");

    a_taken_has_sample: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.accepted) |-> rsp.have_sample)
        else $error("taken sample reported without have_sample");
`endif

endmodule

FILE: design/llavg_regs.sv
// APB configuration registers: stale timeout and the four level limits.
// Depends on llavg_pkg.
`timescale 1ns / 1ps

module llavg_regs (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [llavg_pkg::APB_AW-1:0]   paddr,
    input  logic [llavg_pkg::APB_DW-1:0]   pwdata,
    output logic [llavg_pkg::APB_DW-1:0]   prdata,
    output logic                           pready,
    output llavg_pkg::cfg_t                cfg
);

    llavg_pkg::cfg_t                  cfg_reg;
    logic [llavg_pkg::IDX_W-1:0]      idx;
    logic                             wr_en;

    assign idx    = paddr[llavg_pkg::APB_AW-1:2];
    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite & pready;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.timeout <= llavg_pkg::TIMEOUT_RST;
            cfg_reg.dark    <= llavg_pkg::DARK_RST;
            cfg_reg.dim     <= llavg_pkg::DIM_RST;
            cfg_reg.normal  <= llavg_pkg::NORMAL_RST;
            cfg_reg.bright  <= llavg_pkg::BRIGHT_RST;
        end
        else if (wr_en)
        begin
            case (idx)
                llavg_pkg::REG_TIMEOUT: cfg_reg.timeout <= pwdata;
                llavg_pkg::REG_DARK:    cfg_reg.dark    <= pwdata[llavg_pkg::LUX_W-1:0];
                llavg_pkg::REG_DIM:     cfg_reg.dim     <= pwdata[llavg_pkg::LUX_W-1:0];
                llavg_pkg::REG_NORMAL:  cfg_reg.normal  <= pwdata[llavg_pkg::LUX_W-1:0];
                llavg_pkg::REG_BRIGHT:  cfg_reg.bright  <= pwdata[llavg_pkg::LUX_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            llavg_pkg::REG_TIMEOUT: prdata = cfg_reg.timeout;
            llavg_pkg::REG_DARK:    prdata = llavg_pkg::APB_DW'(cfg_reg.dark);
            llavg_pkg::REG_DIM:     prdata = llavg_pkg::APB_DW'(cfg_reg.dim);
            llavg_pkg::REG_NORMAL:  prdata = llavg_pkg::APB_DW'(cfg_reg.normal);
            llavg_pkg::REG_BRIGHT:  prdata = llavg_pkg::APB_DW'(cfg_reg.bright);
            default:                prdata = '0;
        endcase
    end

endmodule

FILE: design/llavg_div.sv
// Restoring divider, one quotient bit per cycle, for the window average.
// Depends on llavg_pkg for the status struct.
`timescale 1ns / 1ps

module llavg_div #(
    parameter int DVD_W = 21,
    parameter int DVS_W = 4
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [DVD_W-1:0]      dividend,
    input  logic [DVS_W-1:0]      divisor,
    output logic [DVD_W-1:0]      quotient,
    output llavg_pkg::div_stat_t  stat
);

    localparam int CW = $clog2(DVD_W + 1);

    logic [DVD_W-1:0] dvd_reg;
    logic [DVS_W-1:0] dvs_reg;
    logic [DVS_W-1:0] rem_reg;
    logic [CW-1:0]    cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [DVS_W:0]   trial;
    logic [DVS_W:0]   diff;
    logic             fits;

    // Partial remainder shifted left by one with the next dividend bit.
    assign trial = {rem_reg, dvd_reg[DVD_W-1]};
    assign diff  = trial - {1'b0, dvs_reg};
    assign fits  = trial >= {1'b0, dvs_reg};

    assign quotient  = dvd_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dvd_reg  <= '0;
            dvs_reg  <= '0;
            rem_reg  <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            // Done pulses for one cycle after the last quotient bit.
            done_reg <= !start && busy_reg && (cnt_reg == CW'(1));
            if (start)
            begin
                dvd_reg  <= dividend;
                dvs_reg  <= divisor;
                rem_reg  <= '0;
                cnt_reg  <= CW'(DVD_W);
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                // Quotient bits fill the dividend register from the bottom.
                dvd_reg <= {dvd_reg[DVD_W-2:0], fits};
                rem_reg <= fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

endmodule

FILE: tb/sv/light_level_averager_tb.sv
// Self-checking bench for light_level_averager: a table of directed events, then random
// events in five register settings, each beat checked against the table or a local predictor.
// Depends on llavg_pkg, the llavg_in_if / llavg_out_if interfaces and the block itself.
`timescale 1ns / 1ps

module light_level_averager_tb;

    localparam int LUX_W    = llavg_pkg::LUX_W;
    localparam int RAW_W    = llavg_pkg::RAW_W;
    localparam int TIME_W   = llavg_pkg::TIME_W;
    localparam int CNT_W    = llavg_pkg::CNT_W;
    localparam int LEVEL_W  = llavg_pkg::LEVEL_W;
    localparam int STATUS_W = llavg_pkg::STATUS_W;
    localparam int MODE_W   = llavg_pkg::MODE_W;
    localparam int IDX_W    = llavg_pkg::IDX_W;
    localparam int APB_AW   = llavg_pkg::APB_AW;
    localparam int APB_DW   = llavg_pkg::APB_DW;

    localparam int WINDOW          = llavg_pkg::DEPTH_DEF;
    localparam int LUX_MAX         = (1 << LUX_W) - 1;
    localparam int SETTLE_CYCLES   = 40;
    localparam int HOLD_CYCLES     = 300;
    localparam int STALL_LIMIT     = 5000;
    localparam int REPORT_LIMIT    = 10;
    localparam int PHASES          = 5;
    localparam int ITEMS_PER_PHASE = 100;
    localparam int DIRECTED_ROWS   = 25;

    // The event code that the block must ignore, and two register slots that decode to nothing.
    localparam logic [MODE_W-1:0] MODE_UNUSED  = 2'd3;
    localparam logic [IDX_W-1:0]  REG_SPARE_LO = 3'd5;
    localparam logic [IDX_W-1:0]  REG_SPARE_HI = 3'd7;

    typedef struct packed {
        logic                accepted;
        logic [LUX_W-1:0]    last_lux;
        logic [LUX_W-1:0]    mean_lux;
        logic [LEVEL_W-1:0]  level;
        logic [STATUS_W-1:0] status;
        logic [CNT_W-1:0]    good_reads;
        logic [CNT_W-1:0]    bad_reads;
        logic                have_sample;
    } light_report_t;

    // One row of the directed table. Where typed is set, want is the expected beat as it
    // can be read straight off the behavior; otherwise the predictor supplies it.
    typedef struct {
        logic [MODE_W-1:0] mode;
        logic [RAW_W-1:0]  lux;
        logic [TIME_W-1:0] now_ms;
        logic              typed;
        light_report_t     want;
    } probe_row_t;

    // Nothing has been taken yet: status starts out stale and every count is zero.
    localparam light_report_t AT_RESET =
        '{1'b0, 18'd0, 18'd0, llavg_pkg::LEVEL_DARK, llavg_pkg::STATUS_STALE, 32'd0, 32'd0,
          1'b0};
    localparam light_report_t AFTER_ERROR =
        '{1'b0, 18'd0, 18'd0, llavg_pkg::LEVEL_DARK, llavg_pkg::STATUS_ERROR, 32'd0, 32'd1,
          1'b0};
    // The first sample is the largest one; a window of one averages to itself.
    localparam light_report_t FIRST_PEAK =
        '{1'b1, 18'h3FFFF, 18'h3FFFF, llavg_pkg::LEVEL_VERY_BRIGHT, llavg_pkg::STATUS_OK,
          32'd1, 32'd1, 1'b1};
    localparam light_report_t BY_MODEL = '0;

    // Directed events, all under the reset register values (timeout 1000 ms,
    // limits 40 / 400 / 2000 / 4000).
    probe_row_t directed_rows [DIRECTED_ROWS] = '{
        // A status check before any sample changes nothing.
        '{llavg_pkg::MODE_CHECK,  19'd0,      32'd5000,      1'b1, AT_RESET},
        // Negative samples, minus one and the most negative, are turned away.
        '{llavg_pkg::MODE_SAMPLE, 19'h7FFFF,  32'd10,        1'b1, AT_RESET},
        '{llavg_pkg::MODE_SAMPLE, 19'h40000,  32'd20,        1'b1, AT_RESET},
        // The unused event code is dropped without a trace.
        '{MODE_UNUSED,            19'd123,    32'd30,        1'b1, AT_RESET},
        '{llavg_pkg::MODE_ERROR,  19'd0,      32'd0,         1'b1, AFTER_ERROR},
        '{llavg_pkg::MODE_CHECK,  19'd0,      32'd9999,      1'b1, AFTER_ERROR},
        '{llavg_pkg::MODE_SAMPLE, 19'h3FFFF,  32'd100,       1'b1, FIRST_PEAK},
        '{llavg_pkg::MODE_SAMPLE, 19'd0,      32'd200,       1'b0, BY_MODEL},
        // Exactly the timeout since the last sample is not yet stale; one more is.
        '{llavg_pkg::MODE_CHECK,  19'd0,      32'd1200,      1'b0, BY_MODEL},
        '{llavg_pkg::MODE_CHECK,  19'd0,      32'd1201,      1'b0, BY_MODEL},
        '{llavg_pkg::MODE_ERROR,  19'h7FFFF,  32'hFFFF_FFFF, 1'b0, BY_MODEL},
        // A check inside the timeout leaves the sensor error standing.
        '{llavg_pkg::MODE_CHECK,  19'd0,      32'd1100,      1'b0, BY_MODEL},
        // Sample just below the wrap point of the clock, then checks across the wrap.
        '{llavg_pkg::MODE_SAMPLE, 19'd39,     32'hFFFF_FF00, 1'b0, BY_MODEL},
        '{llavg_pkg::MODE_CHECK,  19'd0,      32'h0000_0010, 1'b0, BY_MODEL},
        '{llavg_pkg::MODE_CHECK,  19'd0,      32'h0000_02E8, 1'b0, BY_MODEL},
        '{llavg_pkg::MODE_CHECK,  19'd0,      32'h0000_02E9, 1'b0, BY_MODEL},
        // Samples on either side of every limit; the ring wraps along the way.
        '{llavg_pkg::MODE_SAMPLE, 19'd40,     32'd3000,      1'b0, BY_MODEL},
        '{llavg_pkg::MODE_SAMPLE, 19'd399,    32'd3100,      1'b0, BY_MODEL},
        '{llavg_pkg::MODE_SAMPLE, 19'd400,    32'd3200,      1'b0, BY_MODEL},
        '{llavg_pkg::MODE_SAMPLE, 19'd1999,   32'd3300,      1'b0, BY_MODEL},
        '{llavg_pkg::MODE_SAMPLE, 19'd2000,   32'd3400,      1'b0, BY_MODEL},
        '{llavg_pkg::MODE_SAMPLE, 19'd3999,   32'd3500,      1'b0, BY_MODEL},
        '{llavg_pkg::MODE_SAMPLE, 19'd4000,   32'd3600,      1'b0, BY_MODEL},
        '{llavg_pkg::MODE_SAMPLE, 19'h3FFFF,  32'd3700,      1'b0, BY_MODEL},
        '{MODE_UNUSED,            19'h7FFFF,  32'hFFFF_FFFF, 1'b0, BY_MODEL}
    };

    // Register settings per phase. Phase 0 keeps the reset values, phase 1 puts every
    // limit and the timeout at zero, phase 2 at their maximum, phase 3 uses limits out of
    // order, and phase 4 draws a sorted set at random.
    llavg_pkg::cfg_t phase_cfg [PHASES] = '{
        '{llavg_pkg::TIMEOUT_RST, llavg_pkg::DARK_RST, llavg_pkg::DIM_RST,
          llavg_pkg::NORMAL_RST, llavg_pkg::BRIGHT_RST},
        '{32'd0,         18'd0,      18'd0,     18'd0,      18'd0},
        '{32'hFFFF_FFFF, 18'h3FFFF,  18'h3FFFF, 18'h3FFFF,  18'h3FFFF},
        '{32'd50,        18'd3000,   18'd100,   18'd5000,   18'd200},
        '{32'd1000,      18'd0,      18'd0,     18'd0,      18'd0}
    };
    // Chance in percent that either side idles after a beat; phase 2 runs with no idling.
    int phase_idle [PHASES] = '{30, 40, 0, 25, 60};

    logic                clk;
    logic                rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [APB_AW-1:0]   paddr;
    logic [APB_DW-1:0]   pwdata;
    logic [APB_DW-1:0]   prdata;
    logic                pready;

    llavg_in_if  req_ch ();
    llavg_out_if rsp_ch ();

    light_level_averager i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .req     (req_ch),
        .rsp     (rsp_ch)
    );

    // Predictor state: a copy of the sample ring, the running figures and the registers.
    logic [LUX_W-1:0]    ring [WINDOW];
    int unsigned         ring_slot;
    int unsigned         ring_count;
    int unsigned         ring_sum;
    logic [LUX_W-1:0]    model_latest;
    logic [LUX_W-1:0]    model_mean;
    logic [LEVEL_W-1:0]  model_level;
    logic [STATUS_W-1:0] model_health;
    logic [TIME_W-1:0]   model_last_time;
    logic [CNT_W-1:0]    good_total;
    logic [CNT_W-1:0]    bad_total;
    logic                model_seen;
    llavg_pkg::cfg_t     shadow_cfg;

    light_report_t expected_reports [$];
    int            fault_count;
    int            idle_pct;
    logic          hold_rsp;
    logic [TIME_W-1:0] clock_ms;

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    task automatic note_fault(input string what);
        fault_count++;
        if (fault_count <= REPORT_LIMIT)
        begin
            $display("%0t ns: mismatch, %s", $time, what);
        end
    endtask

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (got !== want)
        begin
            note_fault($sformatf("%s expected %0d (0x%0h), got %0d (0x%0h)",
                                 name, want, want, got, got));
        end
    endtask

    // Gap lengths come from three ranges, short, medium and long, drawn 80, 16 and 4 percent of the time.
    function automatic int gap_len();
        int r;
        r = $urandom_range(99);
        if (r < 80)
        begin
            return $urandom_range(3, 1);
        end
        else if (r < 96)
        begin
            return $urandom_range(12, 4);
        end
        return $urandom_range(80, 20);
    endfunction

    // The first limit that the average lies below decides the level.
    function automatic logic [LEVEL_W-1:0] light_band(input logic [LUX_W-1:0] avg);
        if (avg < shadow_cfg.dark)
        begin
            return llavg_pkg::LEVEL_DARK;
        end
        if (avg < shadow_cfg.dim)
        begin
            return llavg_pkg::LEVEL_DIM;
        end
        if (avg < shadow_cfg.normal)
        begin
            return llavg_pkg::LEVEL_NORMAL;
        end
        if (avg < shadow_cfg.bright)
        begin
            return llavg_pkg::LEVEL_BRIGHT;
        end
        return llavg_pkg::LEVEL_VERY_BRIGHT;
    endfunction

    // Applies one accepted event to the predictor state and returns the beat that the
    // block must send back for it.
    function automatic light_report_t step_light_state(input logic [MODE_W-1:0] mode,
                                                       input logic [RAW_W-1:0]  lux,
                                                       input logic [TIME_W-1:0] now_ms);
        light_report_t     view;
        logic [TIME_W-1:0] elapsed;
        logic              took;
        took = 1'b0;
        case (mode)
            llavg_pkg::MODE_SAMPLE:
            begin
                if (!lux[RAW_W-1])
                begin
                    // Once the ring is full, the oldest entry leaves the sum.
                    if (ring_count < WINDOW)
                    begin
                        ring_count++;
                    end
                    else
                    begin
                        ring_sum -= 32'(ring[ring_slot]);
                    end
                    ring[ring_slot] = lux[LUX_W-1:0];
                    ring_sum += 32'(lux[LUX_W-1:0]);
                    ring_slot = (ring_slot == WINDOW - 1) ? 0 : ring_slot + 1;
                    model_latest = lux[LUX_W-1:0];
                    model_mean = LUX_W'(ring_sum / ring_count);
                    model_level = light_band(model_mean);
                    model_health = llavg_pkg::STATUS_OK;
                    model_last_time = now_ms;
                    good_total++;
                    model_seen = 1'b1;
                    took = 1'b1;
                end
            end
            llavg_pkg::MODE_ERROR:
            begin
                bad_total++;
                model_health = llavg_pkg::STATUS_ERROR;
            end
            llavg_pkg::MODE_CHECK:
            begin
                // Elapsed time wraps with the clock; only strictly beyond the timeout is stale.
                elapsed = now_ms - model_last_time;
                if (model_seen && elapsed > shadow_cfg.timeout)
                begin
                    model_health = llavg_pkg::STATUS_STALE;
                end
            end
            default:
            begin
            end
        endcase
        view.accepted    = took;
        view.last_lux    = model_latest;
        view.mean_lux    = model_mean;
        view.level       = model_level;
        view.status      = model_health;
        view.good_reads  = good_total;
        view.bad_reads   = bad_total;
        view.have_sample = model_seen;
        return view;
    endfunction

    // One APB transfer, setup then access. It starts on a clock edge and drops psel before it
    // returns, so that psel never falls and rises within a single edge.
    task automatic apb_cycle(input logic [IDX_W-1:0] idx, input logic wr,
                             input logic [APB_DW-1:0] wdata, output logic [APB_DW-1:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
        begin
            @(posedge clk);
        end
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // Writes a register, mirrors it in the shadow copy and reads it back. The limits keep
    // only their low bits, so junk in the upper bits of the write must not come back.
    task automatic set_register(input logic [IDX_W-1:0] idx, input logic [APB_DW-1:0] value);
        logic [APB_DW-1:0] readback;
        logic [APB_DW-1:0] held;
        apb_cycle(idx, 1'b1, value, readback);
        case (idx)
            llavg_pkg::REG_TIMEOUT: shadow_cfg.timeout = value;
            llavg_pkg::REG_DARK:    shadow_cfg.dark    = value[LUX_W-1:0];
            llavg_pkg::REG_DIM:     shadow_cfg.dim     = value[LUX_W-1:0];
            llavg_pkg::REG_NORMAL:  shadow_cfg.normal  = value[LUX_W-1:0];
            llavg_pkg::REG_BRIGHT:  shadow_cfg.bright  = value[LUX_W-1:0];
            default:
            begin
            end
        endcase
        if (idx <= llavg_pkg::REG_BRIGHT)
        begin
            held = (idx == llavg_pkg::REG_TIMEOUT) ? value : APB_DW'(value[LUX_W-1:0]);
            apb_cycle(idx, 1'b0, '0, readback);
            compare_field($sformatf("register %0d readback", idx), held, readback);
        end
    endtask

    task automatic write_settings(input llavg_pkg::cfg_t plan);
        set_register(llavg_pkg::REG_TIMEOUT, plan.timeout);
        set_register(llavg_pkg::REG_DARK,    {(APB_DW - LUX_W)'($urandom), plan.dark});
        set_register(llavg_pkg::REG_DIM,     {(APB_DW - LUX_W)'($urandom), plan.dim});
        set_register(llavg_pkg::REG_NORMAL,  {(APB_DW - LUX_W)'($urandom), plan.normal});
        set_register(llavg_pkg::REG_BRIGHT,  {(APB_DW - LUX_W)'($urandom), plan.bright});
    endtask

    // Presents one event and holds it until the block takes it; the prediction is made at
    // the edge of the handshake. Called on a clock edge, returns on the accepting edge.
    task automatic offer_event(input logic [MODE_W-1:0] mode, input logic [RAW_W-1:0] lux,
                               input logic [TIME_W-1:0] now_ms,
                               output light_report_t predicted);
        req_ch.valid  <= 1'b1;
        req_ch.mode   <= mode;
        req_ch.lux    <= lux;
        req_ch.now_ms <= now_ms;
        @(posedge clk);
        while (!req_ch.ready)
        begin
            @(posedge clk);
        end
        predicted = step_light_state(mode, lux, now_ms);
    endtask

    // At the phase's idle chance, drops valid for a random stretch; the gap is never zero, so
    // valid is not lowered and raised on the same edge.
    task automatic sender_gap();
        int g;
        if ($urandom_range(99) < idle_pct)
        begin
            g = gap_len();
            req_ch.valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
    endtask

    task automatic wait_for_quiet();
        while (expected_reports.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Random event. Three values in ten land near a limit, so that averages cross
    // level boundaries; checks are aimed at the timeout edge measured from the last sample.
    task automatic draw_event(output logic [MODE_W-1:0] mode, output logic [RAW_W-1:0] lux,
                              output logic [TIME_W-1:0] now_ms);
        int               pick;
        int               near;
        logic [LUX_W-1:0] limit;
        pick = $urandom_range(99);
        if (pick < 55)
        begin
            mode = llavg_pkg::MODE_SAMPLE;
        end
        else if (pick < 70)
        begin
            mode = llavg_pkg::MODE_ERROR;
        end
        else if (pick < 95)
        begin
            mode = llavg_pkg::MODE_CHECK;
        end
        else
        begin
            mode = MODE_UNUSED;
        end

        case ($urandom_range(9))
            0:
            begin
                lux = {1'b1, LUX_W'($urandom)};
            end
            1, 2:
            begin
                lux = RAW_W'($urandom);
            end
            3, 4, 5:
            begin
                case ($urandom_range(3))
                    0: limit = shadow_cfg.dark;
                    1: limit = shadow_cfg.dim;
                    2: limit = shadow_cfg.normal;
                    default: limit = shadow_cfg.bright;
                endcase
                near = int'(limit) + int'($urandom_range(4)) - 2;
                if (near < 0)
                begin
                    near = 0;
                end
                if (near > LUX_MAX)
                begin
                    near = LUX_MAX;
                end
                lux = RAW_W'(near);
            end
            default:
            begin
                lux = RAW_W'($urandom_range(5000));
            end
        endcase

        if ($urandom_range(19) == 0)
        begin
            clock_ms = $urandom;
        end
        else
        begin
            clock_ms += $urandom_range(3000);
        end
        now_ms = clock_ms;
        if (mode == llavg_pkg::MODE_CHECK)
        begin
            case ($urandom_range(4))
                0: now_ms = model_last_time + shadow_cfg.timeout;
                1: now_ms = model_last_time + shadow_cfg.timeout + 32'd1;
                2: now_ms = model_last_time + shadow_cfg.timeout - 32'd1;
                default:
                begin
                end
            endcase
        end
    endtask

    // Result side. Ready idles at random; on request it stays low for a long stretch,
    // counted here, so that the block fills up and pushes back on its input.
    initial
    begin
        rsp_ch.ready <= 1'b0;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            if (hold_rsp)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_rsp = 1'b0;
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
                @(posedge clk);
                if ($urandom_range(99) < idle_pct)
                begin
                    rsp_ch.ready <= 1'b0;
                    repeat (gap_len()) @(posedge clk);
                end
            end
        end
    end

    // Every result beat is matched against the oldest prediction, field by field.
    always @(posedge clk)
    begin
        light_report_t got;
        light_report_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            got.accepted    = rsp_ch.accepted;
            got.last_lux    = rsp_ch.last_lux;
            got.mean_lux    = rsp_ch.mean_lux;
            got.level       = rsp_ch.level;
            got.status      = rsp_ch.status;
            got.good_reads  = rsp_ch.good_reads;
            got.bad_reads   = rsp_ch.bad_reads;
            got.have_sample = rsp_ch.have_sample;
            if (expected_reports.size() == 0)
            begin
                note_fault("result beat arrived with nothing expected");
            end
            else
            begin
                want = expected_reports.pop_front();
                compare_field("accepted",    32'(want.accepted),    32'(got.accepted));
                compare_field("last_lux",    32'(want.last_lux),    32'(got.last_lux));
                compare_field("mean_lux",    32'(want.mean_lux),    32'(got.mean_lux));
                compare_field("level",       32'(want.level),       32'(got.level));
                compare_field("status",      32'(want.status),      32'(got.status));
                compare_field("good_reads",  want.good_reads,       got.good_reads);
                compare_field("bad_reads",   want.bad_reads,        got.bad_reads);
                compare_field("have_sample", 32'(want.have_sample), 32'(got.have_sample));
            end
        end
    end

    // Watchdog: the run is hung once the quiet count, with no beat and no register access,
    // reaches STALL_LIMIT.
    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
                || (psel && penable))
            begin
                quiet = 0;
            end
            else
            begin
                quiet++;
            end
        end
        $display("[light_level_averager] ERROR");
        $finish;
    end

    // Stimulus: reset, the directed table, then five phases of random events.
    initial
    begin
        light_report_t     predicted;
        logic [MODE_W-1:0] mode;
        logic [RAW_W-1:0]  lux;
        logic [TIME_W-1:0] now_ms;
        llavg_pkg::cfg_t   plan;
        int                count;
        logic              paused;

        rst_n         <= 1'b0;
        req_ch.valid  <= 1'b0;
        req_ch.mode   <= llavg_pkg::MODE_SAMPLE;
        req_ch.lux    <= '0;
        req_ch.now_ms <= '0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;

        fault_count     = 0;
        hold_rsp        = 1'b0;
        clock_ms        = '0;
        idle_pct        = phase_idle[0];
        ring_slot       = 0;
        ring_count      = 0;
        ring_sum        = 0;
        model_latest    = '0;
        model_mean      = '0;
        model_level     = llavg_pkg::LEVEL_DARK;
        model_health    = llavg_pkg::STATUS_STALE;
        model_last_time = '0;
        good_total      = '0;
        bad_total       = '0;
        model_seen      = 1'b0;
        shadow_cfg      = '{llavg_pkg::TIMEOUT_RST, llavg_pkg::DARK_RST, llavg_pkg::DIM_RST,
                            llavg_pkg::NORMAL_RST, llavg_pkg::BRIGHT_RST};

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            offer_event(directed_rows[i].mode, directed_rows[i].lux, directed_rows[i].now_ms,
                        predicted);
            expected_reports.push_back(directed_rows[i].typed ? directed_rows[i].want
                                                               : predicted);
            sender_gap();
        end

        for (int p = 0; p < PHASES; p++)
        begin
            idle_pct = phase_idle[p];
            if (p > 0)
            begin
                // Registers change only with the block idle and every result returned.
                req_ch.valid <= 1'b0;
                wait_for_quiet();
                plan = phase_cfg[p];
                if (p == PHASES - 1)
                begin
                    plan.timeout = $urandom_range(3000, 1);
                    plan.dark    = LUX_W'($urandom_range(3000));
                    plan.dim     = plan.dark + LUX_W'($urandom_range(3000));
                    plan.normal  = plan.dim + LUX_W'($urandom_range(3000));
                    plan.bright  = plan.normal + LUX_W'($urandom_range(3000));
                end
                write_settings(plan);
                if (p == 2)
                begin
                    // Writes to slots that decode to no register must change nothing.
                    set_register(REG_SPARE_LO, $urandom);
                    set_register(REG_SPARE_HI, $urandom);
                    clock_ms = 32'hFFFF_F000;
                end
            end

            // Long receiver stall while the sender keeps offering events.
            if (p == 1)
            begin
                hold_rsp = 1'b1;
            end

            count  = 0;
            paused = 1'b0;
            while (count < ITEMS_PER_PHASE)
            begin
                // Midway through phase 3 the sender waits until every result is back.
                if (p == 3 && !paused && count >= ITEMS_PER_PHASE / 2)
                begin
                    req_ch.valid <= 1'b0;
                    wait_for_quiet();
                    paused = 1'b1;
                end
                draw_event(mode, lux, now_ms);
                offer_event(mode, lux, now_ms, predicted);
                expected_reports.push_back(predicted);
                if (mode != MODE_UNUSED)
                begin
                    count++;
                end
                sender_gap();
            end
        end

        req_ch.valid <= 1'b0;
        wait_for_quiet();
        if (fault_count == 0)
        begin
            $display("[light_level_averager] OK");
        end
        else
        begin
            $display("[light_level_averager] ERROR");
        end
        $finish;
    end

endmodule

FILE: files.f
design/llavg_pkg.sv
design/llavg_if.sv
design/llavg_regs.sv
design/llavg_div.sv
design/light_level_averager.sv
tb/sv/light_level_averager_tb.sv
